FILE: sv/arpc_pkg.sv
// Shared types, constants and helper functions for the ARP cache table.
`default_nettype none
package arpc_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int TIME_W        = 32;

  typedef enum logic [1:0] {
    SL_FREE     = 2'd0,
    SL_PENDING  = 2'd1,
    SL_RESOLVED = 2'd2,
    SL_TIMEOUT  = 2'd3
  } slot_state_t;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_REPLY  = 3'd3;
  localparam logic [2:0] OP_RESEND = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_TIMED_OUT   = 4'd1;
  localparam logic [3:0] ST_TABLE_FULL  = 4'd2;
  localparam logic [3:0] ST_NOT_FOUND   = 4'd3;
  localparam logic [3:0] ST_HIT         = 4'd4;
  localparam logic [3:0] ST_PEND        = 4'd5;
  localparam logic [3:0] ST_MISS        = 4'd6;
  localparam logic [3:0] ST_BAD_OP      = 4'd7;
  localparam logic [3:0] ST_NOT_PENDING = 4'd8;

  localparam logic [1:0] REG_RESOLVED_TO = 2'd0;
  localparam logic [1:0] REG_HOLD_TO     = 2'd1;
  localparam logic [1:0] REG_RESEND_IVL  = 2'd2;
  localparam logic [1:0] REG_RETRIES     = 2'd3;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DECIDE,
    FSM_WRITE,
    FSM_OUT
  } fsm_t;

  typedef struct packed {
    slot_state_t       st;
    logic [TIME_W-1:0] deadline;
    logic [7:0]        retries;
    logic [31:0]       ip;
    logic [47:0]       mac;
    logic [7:0]        iface;
  } entry_t;

  function automatic logic entry_valid(entry_t e, logic [TIME_W-1:0] now);
    logic in_time;
    in_time = (now <= e.deadline);
    case (e.st)
      SL_RESOLVED, SL_TIMEOUT: entry_valid = in_time;
      SL_PENDING:              entry_valid = (e.retries != 8'd0) || in_time;
      default:                 entry_valid = 1'b0;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] sat_deadline(logic [TIME_W-1:0] now,
                                                      logic [31:0] span);
    logic [TIME_W:0] sum;
    sum = {1'b0, now} + (TIME_W+1)'(span);
    sat_deadline = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/arpc_cell.sv
// One table slot of the rotating ring: loads its neighbour's entry on each shift.
`default_nettype none
module arpc_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift_en,
  input  wire arpc_pkg::entry_t d_in,
  output arpc_pkg::entry_t     q
);
  import arpc_pkg::*;

  entry_t ent_r;

  // Only the slot state is reset; the other fields are never read while the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.st <= SL_FREE;
    end else if (shift_en) begin
      ent_r <= d_in;
    end
  end

  assign q = ent_r;

endmodule
`default_nettype wire

FILE: sv/arp_cache_table.sv
// ARP cache table: ring of slot cells, scan and write-back sequencer, APB registers.
//
// Input beats (in_op, in_ip_addr, in_if_num, in_eth_addr) are taken when in_valid
// is high and in_stall low. Every beat gives exactly one result beat on out_*,
// taken when out_valid is high and out_stall low.
// The table is a ring of slot cells that rotates by one slot per cycle while it
// scans or writes back. A beat is accepted, then a scan over all TABLE_ENTRIES
// slots finds the matching, first free and first reusable slot, a decision step
// follows, and, when a slot changes, a second rotation writes it back; then the
// result is loaded into the output register. Tick and bad codes skip the scan
// and the write-back.
// One beat is worked on at a time; in_stall is high until the result has moved
// into the output register, which holds it while out_stall is high. Reset frees
// every slot, clears time to zero and loads the default timeouts (1200, 200 and
// 10 ticks, 3 retries). Registers must be written only while idle (unchecked).
`default_nettype none
module arp_cache_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_op,
  input  wire logic [31:0] in_ip_addr,
  input  wire logic [7:0]  in_if_num,
  input  wire logic [47:0] in_eth_addr,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_status,
  output logic [47:0]      out_mac_out,
  output logic [7:0]       out_iface_out,
  output logic [3:0]       out_slot_index,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import arpc_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  // Configuration registers
  logic [31:0] res_to_r, hold_to_r, resend_ivl_r;
  logic [7:0]  retries_cfg_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_to_r      <= 32'd1200;
      hold_to_r     <= 32'd200;
      resend_ivl_r  <= 32'd10;
      retries_cfg_r <= 8'd3;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RESOLVED_TO: res_to_r      <= pwdata;
        REG_HOLD_TO:     hold_to_r     <= pwdata;
        REG_RESEND_IVL:  resend_ivl_r  <= pwdata;
        REG_RETRIES:     retries_cfg_r <= pwdata[7:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RESOLVED_TO: prdata = res_to_r;
      REG_HOLD_TO:     prdata = hold_to_r;
      REG_RESEND_IVL:  prdata = resend_ivl_r;
      REG_RETRIES:     prdata = {24'd0, retries_cfg_r};
      default:         prdata = 32'd0;
    endcase
  end

  // Sequencer state
  fsm_t             state_r, state_nxt;
  logic [IDX_W-1:0] idx_r;
  logic             shift_en, in_acc, out_load, idx_last;

  // Latched beat
  logic [2:0]  op_r;
  logic [31:0] ip_r;
  logic [7:0]  ifn_r;
  logic [47:0] eth_r;

  logic [TIME_W-1:0] now_r;

  // Scan results
  logic             mf_r, ff_r, cf_r;
  logic [IDX_W-1:0] mi_r, fi_r, ci_r;
  entry_t           m_r;

  // Decision results
  logic             wr_r;
  logic [IDX_W-1:0] tgt_r;
  entry_t           new_r;
  logic [3:0]       res_status_r;
  logic [47:0]      res_mac_r;
  logic [7:0]       res_ifo_r;
  logic [3:0]       res_slot_r;

  logic             d_wr;
  logic [IDX_W-1:0] d_tgt;
  entry_t           d_new;
  logic [3:0]       d_status;
  logic [47:0]      d_mac;
  logic [7:0]       d_ifo;
  logic [3:0]       d_slot;

  // Ring of cells
  entry_t cell_q [TABLE_ENTRIES];
  entry_t head, head_back;
  logic   head_valid;

  assign head       = cell_q[0];
  assign head_valid = entry_valid(head, now_r);
  assign head_back  = (state_r == FSM_WRITE && wr_r && idx_r == tgt_r) ? new_r : head;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_ring
    entry_t d_in;
    if (g == TABLE_ENTRIES - 1) begin : g_tail
      assign d_in = head_back;
    end else begin : g_mid
      assign d_in = cell_q[g+1];
    end
    arpc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (d_in),
      .q        (cell_q[g])
    );
  end

  assign idx_last = (idx_r == IDX_LAST);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE:   if (in_acc) begin
                    state_nxt = (in_op == OP_TICK || in_op > OP_TICK) ? FSM_DECIDE
                                                                     : FSM_SCAN;
                  end
      FSM_SCAN:   if (idx_last) state_nxt = FSM_DECIDE;
      FSM_DECIDE: state_nxt = d_wr ? FSM_WRITE : FSM_OUT;
      FSM_WRITE:  if (idx_last) state_nxt = FSM_OUT;
      FSM_OUT:    if (out_load) state_nxt = FSM_IDLE;
      default:    state_nxt = FSM_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    shift_en = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      FSM_IDLE:   in_stall = 1'b0;
      FSM_SCAN:   shift_en = 1'b1;
      FSM_DECIDE: ;
      FSM_WRITE:  shift_en = 1'b1;
      FSM_OUT:    out_load = !out_valid || !out_stall;
      default:    ;
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (shift_en) idx_r <= idx_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_op;
      ip_r  <= in_ip_addr;
      ifn_r <= in_if_num;
      eth_r <= in_eth_addr;
    end
  end

  // Scan: first match, first free slot, first reusable slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mf_r <= 1'b0;
      ff_r <= 1'b0;
      cf_r <= 1'b0;
    end else if (in_acc) begin
      mf_r <= 1'b0;
      ff_r <= 1'b0;
      cf_r <= 1'b0;
    end else if (state_r == FSM_SCAN) begin
      if (!mf_r && head.st != SL_FREE && head.ip == ip_r) mf_r <= 1'b1;
      if (!ff_r && head.st == SL_FREE) ff_r <= 1'b1;
      if (!cf_r && head.st != SL_FREE && head.st != SL_PENDING && !head_valid)
        cf_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == FSM_SCAN) begin
      if (!mf_r && head.st != SL_FREE && head.ip == ip_r) begin
        mi_r <= idx_r;
        m_r  <= head;
      end
      if (!ff_r && head.st == SL_FREE) fi_r <= idx_r;
      if (!cf_r && head.st != SL_FREE && head.st != SL_PENDING && !head_valid)
        ci_r <= idx_r;
    end
  end

  // Decision on the scanned table
  always_comb begin
    entry_t pend;
    logic   mvalid;
    pend.st       = SL_PENDING;
    pend.deadline = now_r;
    pend.retries  = retries_cfg_r;
    pend.ip       = ip_r;
    pend.mac      = 48'd0;
    pend.iface    = ifn_r;
    mvalid        = entry_valid(m_r, now_r);

    d_wr     = 1'b0;
    d_tgt    = mi_r;
    d_new    = m_r;
    d_status = ST_OK;
    d_mac    = 48'd0;
    d_ifo    = 8'd0;
    d_slot   = 4'd0;

    case (op_r)
      OP_ADD: begin
        if (mf_r) begin
          d_slot = 4'(mi_r);
          if (mvalid) begin
            d_status = (m_r.st == SL_TIMEOUT) ? ST_TIMED_OUT : ST_OK;
            d_ifo    = m_r.iface;
          end else if (m_r.st == SL_PENDING && m_r.retries == 8'd0 &&
                       now_r >= m_r.deadline) begin
            d_wr           = 1'b1;
            d_new.st       = SL_TIMEOUT;
            d_new.deadline = sat_deadline(now_r, hold_to_r);
            d_new.retries  = 8'd0;
            d_ifo          = m_r.iface;
          end else begin
            d_wr  = 1'b1;
            d_new = pend;
            d_ifo = ifn_r;
          end
        end else if (ff_r || cf_r) begin
          // A free slot anywhere wins over an earlier reusable one.
          d_tgt  = ff_r ? fi_r : ci_r;
          d_slot = 4'(d_tgt);
          d_wr   = 1'b1;
          d_new  = pend;
          d_ifo  = ifn_r;
        end else begin
          d_status = ST_TABLE_FULL;
        end
      end
      OP_DELETE: begin
        if (mf_r) begin
          d_slot         = 4'(mi_r);
          d_ifo          = m_r.iface;
          d_wr           = 1'b1;
          d_new.st       = SL_FREE;
          d_new.deadline = '0;
          d_new.retries  = 8'd0;
          d_new.ip       = 32'd0;
          d_new.mac      = 48'd0;
          d_new.iface    = 8'd0;
        end else begin
          d_status = ST_NOT_FOUND;
        end
      end
      OP_LOOKUP: begin
        if (mf_r && mvalid) begin
          d_slot = 4'(mi_r);
          d_ifo  = m_r.iface;
          if (m_r.st == SL_RESOLVED) begin
            d_status = ST_HIT;
            d_mac    = m_r.mac;
          end else if (m_r.st == SL_TIMEOUT) begin
            d_status = ST_TIMED_OUT;
          end else begin
            d_status = ST_PEND;
          end
        end else begin
          d_status = ST_MISS;
        end
      end
      OP_REPLY: begin
        if (mf_r) begin
          d_slot = 4'(mi_r);
          d_ifo  = m_r.iface;
          if (m_r.st == SL_PENDING) begin
            d_wr           = 1'b1;
            d_new.st       = SL_RESOLVED;
            d_new.deadline = sat_deadline(now_r, res_to_r);
            d_new.retries  = 8'd0;
            d_new.mac      = eth_r;
          end else begin
            d_status = ST_NOT_PENDING;
          end
        end else begin
          d_status = ST_NOT_FOUND;
        end
      end
      OP_RESEND: begin
        if (mf_r) begin
          d_slot = 4'(mi_r);
          d_ifo  = m_r.iface;
          if (m_r.st != SL_PENDING) begin
            d_status = ST_NOT_PENDING;
          end else if (m_r.retries == 8'd0) begin
            d_status = ST_TIMED_OUT;
          end else begin
            d_wr           = 1'b1;
            d_new.retries  = m_r.retries - 8'd1;
            d_new.deadline = sat_deadline(now_r, resend_ivl_r);
          end
        end else begin
          d_status = ST_NOT_FOUND;
        end
      end
      OP_TICK: d_status = ST_OK;
      default: d_status = ST_BAD_OP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
      wr_r  <= 1'b0;
    end else if (state_r == FSM_DECIDE) begin
      wr_r <= d_wr;
      if (op_r == OP_TICK && now_r != {TIME_W{1'b1}}) now_r <= now_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == FSM_DECIDE) begin
      tgt_r        <= d_tgt;
      new_r        <= d_new;
      res_status_r <= d_status;
      res_mac_r    <= d_mac;
      res_ifo_r    <= d_ifo;
      res_slot_r   <= d_slot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status     <= res_status_r;
      out_mac_out    <= res_mac_r;
      out_iface_out  <= res_ifo_r;
      out_slot_index <= res_slot_r;
    end
  end

  // The ring is back in its home position whenever the sequencer rests.
  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FSM_IDLE |-> idx_r == '0)
    else $error("ring not aligned while idle");

  // A write-back pass always ends in the output stage.
  a_write_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FSM_WRITE && idx_last |=> state_r == FSM_OUT)
    else $error("write pass did not end in output stage");

  // A recorded match never refers to a free slot.
  a_match_used: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FSM_DECIDE && mf_r |-> m_r.st != SL_FREE)
    else $error("matched a free slot");

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the ARP cache table: directed table, random phases, APB setup.
`timescale 1ns / 1ps
module tb;
  import arpc_pkg::*;

  typedef struct packed {
    logic [3:0]  status;
    logic [47:0] mac;
    logic [7:0]  iface;
    logic [3:0]  slot;
  } arp_result_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] ip;
    logic [7:0]  ifn;
    logic [47:0] eth;
    logic        known;
    arp_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = OP_TICK;
  logic [31:0] in_ip_addr = '0;
  logic [7:0]  in_if_num = '0;
  logic [47:0] in_eth_addr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_status;
  logic [47:0] out_mac_out;
  logic [7:0]  out_iface_out;
  logic [3:0]  out_slot_index;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  arp_cache_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_ip_addr(in_ip_addr),
    .in_if_num(in_if_num), .in_eth_addr(in_eth_addr),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_mac_out(out_mac_out), .out_iface_out(out_iface_out),
    .out_slot_index(out_slot_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the cache, updated as each beat is accepted.
  slot_state_t   sh_state [TABLE_ENTRIES];
  logic [31:0]   sh_deadline [TABLE_ENTRIES];
  logic [7:0]    sh_retries [TABLE_ENTRIES];
  logic [31:0]   sh_ip [TABLE_ENTRIES];
  logic [47:0]   sh_mac [TABLE_ENTRIES];
  logic [7:0]    sh_iface [TABLE_ENTRIES];
  logic [31:0]   sh_now;
  logic [31:0]   cfg_resolved, cfg_hold, cfg_resend;
  logic [7:0]    cfg_retries;

  arp_result_t   awaited_results[$];
  int            errors = 0;
  bit            no_idle = 1'b0;
  bit            hold_off_req = 1'b0;
  int            stall_left = 0;
  dir_row_t      dir_rows[$];
  logic [31:0]   ip_pool [24];

  function automatic bit slot_live(int i);
    case (sh_state[i])
      SL_RESOLVED, SL_TIMEOUT: return sh_now <= sh_deadline[i];
      SL_PENDING:              return sh_retries[i] != 0 || sh_now <= sh_deadline[i];
      default:                 return 1'b0;
    endcase
  endfunction

  function automatic int find_slot(logic [31:0] ip);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (sh_state[i] != SL_FREE && sh_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic logic [31:0] deadline_after(logic [31:0] span);
    logic [32:0] sum;
    sum = {1'b0, sh_now} + {1'b0, span};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic void make_pending(int i, logic [31:0] ip, logic [7:0] ifn);
    sh_state[i] = SL_PENDING;
    sh_deadline[i] = sh_now;
    sh_retries[i] = cfg_retries;
    sh_iface[i] = ifn;
    sh_ip[i] = ip;
    sh_mac[i] = '0;
  endfunction

  // Applies one beat to the shadow table and returns the result it must give.
  function automatic arp_result_t apply_arp_op(logic [2:0] op, logic [31:0] ip,
                                               logic [7:0] ifn, logic [47:0] eth);
    arp_result_t r;
    int i, hit;
    r = '0;
    hit = -1;
    i = find_slot(ip);
    case (op)
      OP_ADD: begin
        if (i >= 0) begin
          hit = i;
          if (slot_live(i)) begin
            r.status = (sh_state[i] == SL_TIMEOUT) ? ST_TIMED_OUT : ST_OK;
          end else if (sh_state[i] == SL_PENDING && sh_retries[i] == 0 &&
                       sh_now >= sh_deadline[i]) begin
            sh_state[i] = SL_TIMEOUT;
            sh_deadline[i] = deadline_after(cfg_hold);
            sh_retries[i] = '0;
          end else begin
            make_pending(i, ip, ifn);
          end
        end else begin
          for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (sh_state[k] == SL_FREE) begin
              hit = k;
              break;
            end
            if (hit < 0 && sh_state[k] != SL_PENDING && !slot_live(k)) hit = k;
          end
          if (hit < 0) r.status = ST_TABLE_FULL;
          else make_pending(hit, ip, ifn);
        end
        if (hit >= 0) r.iface = sh_iface[hit];
      end
      OP_DELETE: begin
        if (i >= 0) begin
          hit = i;
          r.iface = sh_iface[i];
          sh_state[i] = SL_FREE;
          sh_deadline[i] = '0;
          sh_retries[i] = '0;
          sh_ip[i] = '0;
          sh_mac[i] = '0;
          sh_iface[i] = '0;
        end else r.status = ST_NOT_FOUND;
      end
      OP_LOOKUP: begin
        if (i >= 0 && slot_live(i)) begin
          hit = i;
          r.iface = sh_iface[i];
          if (sh_state[i] == SL_RESOLVED) begin
            r.status = ST_HIT;
            r.mac = sh_mac[i];
          end else if (sh_state[i] == SL_TIMEOUT) r.status = ST_TIMED_OUT;
          else r.status = ST_PEND;
        end else r.status = ST_MISS;
      end
      OP_REPLY: begin
        if (i < 0) r.status = ST_NOT_FOUND;
        else begin
          hit = i;
          if (sh_state[i] == SL_PENDING) begin
            sh_state[i] = SL_RESOLVED;
            sh_deadline[i] = deadline_after(cfg_resolved);
            sh_retries[i] = '0;
            sh_mac[i] = eth;
          end else r.status = ST_NOT_PENDING;
          r.iface = sh_iface[i];
        end
      end
      OP_RESEND: begin
        if (i < 0) r.status = ST_NOT_FOUND;
        else begin
          hit = i;
          r.iface = sh_iface[i];
          if (sh_state[i] != SL_PENDING) r.status = ST_NOT_PENDING;
          else if (sh_retries[i] == 0) r.status = ST_TIMED_OUT;
          else begin
            sh_retries[i] = sh_retries[i] - 8'd1;
            sh_deadline[i] = deadline_after(cfg_resend);
          end
        end
      end
      OP_TICK: if (sh_now != 32'hFFFF_FFFF) sh_now = sh_now + 32'd1;
      default: r.status = ST_BAD_OP;
    endcase
    if (hit >= 0) r.slot = hit[3:0];
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_RESOLVED_TO: cfg_resolved = value;
      REG_HOLD_TO:     cfg_hold = value;
      REG_RESEND_IVL:  cfg_resend = value;
      default:         cfg_retries = value[7:0];
    endcase
  endtask

  // Offers one beat after a random gap (none when no_idle is set) and records what it must produce.
  task automatic send_beat(logic [2:0] op, logic [31:0] ip, logic [7:0] ifn,
                           logic [47:0] eth, bit known, arp_result_t typed);
    int gap;
    arp_result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = op;
    in_ip_addr = ip;
    in_if_num = ifn;
    in_eth_addr = eth;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    r = apply_arp_op(op, ip, ifn, eth);
    awaited_results.push_back(known ? typed : r);
    @(negedge clk);
  endtask

  task automatic settle;
    in_valid = 1'b0;
    wait (awaited_results.size() == 0);
    repeat (50) @(negedge clk);
  endtask

  task automatic add_row(logic [2:0] op, logic [31:0] ip, logic [7:0] ifn,
                         logic [47:0] eth, bit known, logic [3:0] st,
                         logic [7:0] ifo, logic [3:0] slot);
    dir_row_t row;
    row.op = op;
    row.ip = ip;
    row.ifn = ifn;
    row.eth = eth;
    row.known = known;
    row.res = '{status: st, mac: 48'd0, iface: ifo, slot: slot};
    dir_rows.push_back(row);
  endtask

  // Receiver: counts down its hold-off each cycle; a long one is taken on request.
  always @(negedge clk) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      stall_left = 300;
    end
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left = stall_left - 1;
    end else out_stall = 1'b0;
  end

  always @(posedge clk) begin
    arp_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d slot=%0d", $time, out_status,
                 out_slot_index);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_mac_out !== want.mac) begin
          $display("%0t: mac expected %h got %h", $time, want.mac, out_mac_out);
          errors++;
        end
        if (out_iface_out !== want.iface) begin
          $display("%0t: iface expected %0d got %0d", $time, want.iface, out_iface_out);
          errors++;
        end
        if (out_slot_index !== want.slot) begin
          $display("%0t: slot expected %0d got %0d", $time, want.slot, out_slot_index);
          errors++;
        end
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 8);
    end
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    logic [31:0] phase_cfg [5][4];
    int pick;
    logic [2:0] op;
    logic [31:0] ip;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      sh_state[i] = SL_FREE;
      sh_deadline[i] = '0;
      sh_retries[i] = '0;
      sh_ip[i] = '0;
      sh_mac[i] = '0;
      sh_iface[i] = '0;
    end
    sh_now = '0;
    cfg_resolved = 32'd1200;
    cfg_hold = 32'd200;
    cfg_resend = 32'd10;
    cfg_retries = 8'd3;

    add_row(OP_LOOKUP, 32'h0, 8'h00, 48'h0, 1, ST_MISS, 8'h00, 4'd0);
    add_row(OP_DELETE, 32'h1234_5678, 8'h00, 48'h0, 1, ST_NOT_FOUND, 8'h00, 4'd0);
    add_row(OP_REPLY, 32'h1, 8'h00, 48'h0, 1, ST_NOT_FOUND, 8'h00, 4'd0);
    add_row(OP_RESEND, 32'h1, 8'h00, 48'h0, 1, ST_NOT_FOUND, 8'h00, 4'd0);
    add_row(3'd6, 32'hFFFF_FFFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 1, ST_BAD_OP, 8'h00, 4'd0);
    add_row(3'd7, 32'h0, 8'h00, 48'h0, 1, ST_BAD_OP, 8'h00, 4'd0);
    add_row(OP_TICK, 32'h0, 8'h00, 48'h0, 1, ST_OK, 8'h00, 4'd0);
    add_row(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 48'h0, 1, ST_OK, 8'hFF, 4'd0);
    add_row(OP_ADD, 32'h0, 8'h00, 48'hFFFF_FFFF_FFFF, 0, '0, '0, '0);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00, 48'h0, 0, '0, '0, '0);
    add_row(OP_REPLY, 32'hFFFF_FFFF, 8'h00, 48'hFFFF_FFFF_FFFF, 0, '0, '0, '0);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00, 48'h0, 0, '0, '0, '0);
    add_row(OP_REPLY, 32'hFFFF_FFFF, 8'h00, 48'h0, 0, '0, '0, '0);
    add_row(OP_RESEND, 32'hFFFF_FFFF, 8'h00, 48'h0, 0, '0, '0, '0);
    for (int k = 0; k < 4; k++) add_row(OP_RESEND, 32'h0, 8'h00, 48'h0, 0, '0, '0, '0);
    add_row(OP_ADD, 32'h0, 8'h11, 48'h0, 0, '0, '0, '0);
    add_row(OP_LOOKUP, 32'h0, 8'h00, 48'h0, 0, '0, '0, '0);
    add_row(OP_DELETE, 32'hFFFF_FFFF, 8'h00, 48'h0, 0, '0, '0, '0);
    add_row(OP_ADD, 32'h55AA_55AA, 8'hA5, 48'h0, 0, '0, '0, '0);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00, 48'h0, 0, '0, '0, '0);

    phase_cfg = '{'{32'd3, 32'd2, 32'd1, 32'd2},
                  '{32'd0, 32'd0, 32'd0, 32'd0},
                  '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFF},
                  '{32'd6, 32'd1, 32'd2, 32'd1},
                  '{32'd1200, 32'd200, 32'd10, 32'd3}};

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[r])
      send_beat(dir_rows[r].op, dir_rows[r].ip, dir_rows[r].ifn, dir_rows[r].eth,
                dir_rows[r].known, dir_rows[r].res);

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_reg(REG_RESOLVED_TO, phase_cfg[ph][0]);
      write_reg(REG_HOLD_TO, phase_cfg[ph][1]);
      write_reg(REG_RESEND_IVL, phase_cfg[ph][2]);
      write_reg(REG_RETRIES, phase_cfg[ph][3]);
      foreach (ip_pool[k]) ip_pool[k] = $urandom;
      no_idle = (ph == 1 || ph == 3);
      // The long hold-off lets the result buffer fill so that the input stalls.
      if (ph == 2) hold_off_req = 1'b1;
      for (int n = 0; n < 190; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) op = OP_ADD;
        else if (pick < 43) op = OP_LOOKUP;
        else if (pick < 58) op = OP_REPLY;
        else if (pick < 68) op = OP_RESEND;
        else if (pick < 75) op = OP_DELETE;
        else if (pick < 96) op = OP_TICK;
        else op = 3'($urandom_range(6, 7));
        ip = ($urandom_range(0, 19) == 0) ? $urandom : ip_pool[$urandom_range(0, 23)];
        send_beat(op, ip, 8'($urandom), 48'({$urandom, $urandom}), 0, '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
